// ===== sv/mfc_pkg.sv =====
// ---------------------------------------------------------------------------
// mfc_pkg
// Types and constants shared by the mail frame checker files.
// ---------------------------------------------------------------------------
`default_nettype none

package mfc_pkg;

   // field widths
   localparam int BYTE_W = 8;
   localparam int LEN_W  = 16;
   localparam int POS_W  = LEN_W + 1;

   // frame layout: header, length high, length low, control byte
   localparam logic [POS_W-1:0] POS_HDR    = POS_W'(0);
   localparam logic [POS_W-1:0] POS_LEN_HI = POS_W'(1);
   localparam logic [POS_W-1:0] POS_LEN_LO = POS_W'(2);
   localparam logic [POS_W-1:0] POS_CTL    = POS_W'(3);
   localparam logic [POS_W-1:0] POS_MAX    = {POS_W{1'b1}};

   // byte codes
   localparam logic [BYTE_W-1:0] HDR_BYTE  = 8'h10;
   localparam logic [BYTE_W-1:0] SAMB_CODE = 8'hC8;
   localparam logic [1:0]        CTL_UNNUM = 2'b11;

   // verdict codes
   localparam logic [2:0] VERDICT_OK         = 3'd0;
   localparam logic [2:0] VERDICT_NO_HEADER  = 3'd1;
   localparam logic [2:0] VERDICT_TOO_SHORT  = 3'd2;
   localparam logic [2:0] VERDICT_INCOMPLETE = 3'd3;
   localparam logic [2:0] VERDICT_BAD_SUM    = 3'd4;

   // frame kind codes
   localparam logic [1:0] KIND_INFO   = 2'd0;
   localparam logic [1:0] KIND_UNNUM  = 2'd1;
   localparam logic [1:0] KIND_SUPER  = 2'd2;
   localparam logic [1:0] KIND_ABSENT = 2'd3;

   // input word
   typedef struct packed {
      logic [BYTE_W-1:0] rx_byte;
      logic              chunk_last;
   } req_type;

   // result word
   typedef struct packed {
      logic [2:0]        verdict;
      logic [1:0]        frame_kind;
      logic              samb_seen;
      logic [LEN_W-1:0]  payload_length;
      logic [BYTE_W-1:0] sum_received;
      logic [BYTE_W-1:0] sum_computed;
   } rsp_type;

endpackage

`default_nettype wire

// ===== sv/mfc_ifs.sv =====
// ---------------------------------------------------------------------------
// mfc_ifs
// Valid/ready channels for the input bytes and the frame results.
// ---------------------------------------------------------------------------
`default_nettype none

interface mfc_req_if;
   logic             valid;
   logic             ready;
   mfc_pkg::req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface mfc_rsp_if;
   logic             valid;
   logic             ready;
   mfc_pkg::rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/mail_frame_checker_core.sv =====
// ---------------------------------------------------------------------------
// mail_frame_checker_core
// Checks a length-prefixed frame one byte per word and reports one verdict
// on the word that carries the chunk's last byte.
// ---------------------------------------------------------------------------
//  channel   direction  payload                                   words
//  req_ch    in         rx_byte, chunk_last                       every byte
//  rsp_ch    out        verdict, frame_kind, samb_seen,           one per chunk
//                       payload_length, sum_received, sum_computed
//
//  one byte is taken per cycle while req_ch.ready is high; a chunk's
//  result is registered in the result register, or in the skid register
//  frame state (position, length, sum, control byte) updates at the accept
//  edge; a result register plus one skid register hold finished results
//  req_ch.ready drops only when both result registers are full
//  synchronous reset clears the frame state and both result valids
// ---------------------------------------------------------------------------
`default_nettype none

module mail_frame_checker_core (
   input  wire              clock,
   input  wire              reset,
   mfc_req_if.sink          req_ch,
   mfc_rsp_if.source        rsp_ch
);

   // frame state
   logic [mfc_pkg::POS_W-1:0]  pos_ff,  pos_in;
   logic                       hdr_ff,  hdr_in;
   logic [mfc_pkg::LEN_W-1:0]  len_ff,  len_in;
   logic [mfc_pkg::BYTE_W-1:0] sum_ff,  sum_in;
   logic [mfc_pkg::BYTE_W-1:0] ctl_ff,  ctl_in;

   // result registers
   logic             out_valid_ff,  out_valid_in;
   mfc_pkg::rsp_type out_data_ff,   out_data_in;
   logic             skid_valid_ff, skid_valid_in;
   mfc_pkg::rsp_type skid_data_ff,  skid_data_in;

   logic                       accept;
   logic                       res_valid;
   logic                       take;
   logic [mfc_pkg::BYTE_W-1:0] b;
   logic                       hdr_eff;
   logic [mfc_pkg::LEN_W-1:0]  len_eff;
   logic [mfc_pkg::BYTE_W-1:0] ctl_eff;
   logic [mfc_pkg::BYTE_W-1:0] sum_eff;
   logic [mfc_pkg::POS_W-1:0]  limit;
   logic                       short_chunk;
   logic                       before_end;
   mfc_pkg::rsp_type           res;

   // handshake
   assign req_ch.ready = !skid_valid_ff;
   assign accept       = req_ch.valid && !skid_valid_ff;
   assign res_valid    = accept && req_ch.data.chunk_last;
   assign take         = out_valid_ff && rsp_ch.ready;
   assign b            = req_ch.data.rx_byte;

   // state as it stands after this byte
   always_comb begin
      hdr_eff = (pos_ff == mfc_pkg::POS_HDR) ? (b == mfc_pkg::HDR_BYTE) : hdr_ff;
      len_eff = len_ff;
      if (pos_ff == mfc_pkg::POS_LEN_HI) begin
         len_eff = {b, len_ff[7:0]};
      end else if (pos_ff == mfc_pkg::POS_LEN_LO) begin
         len_eff = {len_ff[15:8], b};
      end
      ctl_eff = (pos_ff == mfc_pkg::POS_CTL) ? b : ctl_ff;
      limit       = {1'b0, len_eff} + mfc_pkg::POS_CTL;
      short_chunk = pos_ff < mfc_pkg::POS_CTL;
      before_end  = pos_ff < limit;
      sum_eff = (!short_chunk && before_end) ? sum_ff + b : sum_ff;
   end

   // verdict and frame classification
   always_comb begin
      if (!hdr_eff) begin
         res.verdict = mfc_pkg::VERDICT_NO_HEADER;
      end else if (short_chunk) begin
         res.verdict = mfc_pkg::VERDICT_TOO_SHORT;
      end else if (before_end) begin
         res.verdict = mfc_pkg::VERDICT_INCOMPLETE;
      end else if (b != sum_eff) begin
         res.verdict = mfc_pkg::VERDICT_BAD_SUM;
      end else begin
         res.verdict = mfc_pkg::VERDICT_OK;
      end
      res.samb_seen = 1'b0;
      if (short_chunk) begin
         res.frame_kind = mfc_pkg::KIND_ABSENT;
      end else if (!ctl_eff[7]) begin
         res.frame_kind = mfc_pkg::KIND_INFO;
      end else if (ctl_eff[7:6] == mfc_pkg::CTL_UNNUM) begin
         res.frame_kind = mfc_pkg::KIND_UNNUM;
         res.samb_seen  = (ctl_eff == mfc_pkg::SAMB_CODE);
      end else begin
         res.frame_kind = mfc_pkg::KIND_SUPER;
      end
      res.payload_length = len_eff;
      res.sum_received   = b;
      res.sum_computed   = sum_eff;
   end

   // next frame state: cleared after the last byte of a chunk
   always_comb begin
      pos_in = pos_ff;
      hdr_in = hdr_ff;
      len_in = len_ff;
      sum_in = sum_ff;
      ctl_in = ctl_ff;
      if (accept) begin
         if (req_ch.data.chunk_last) begin
            pos_in = '0;
            hdr_in = 1'b0;
            len_in = '0;
            sum_in = '0;
            ctl_in = '0;
         end else begin
            pos_in = (pos_ff == mfc_pkg::POS_MAX) ? pos_ff : pos_ff + 1'b1;
            hdr_in = hdr_eff;
            len_in = len_eff;
            sum_in = sum_eff;
            ctl_in = ctl_eff;
         end
      end
   end

   // result register with skid stage
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || take) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = res_valid;
            out_data_in  = res;
         end
      end else if (res_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = res;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         hdr_ff        <= 1'b0;
         len_ff        <= '0;
         sum_ff        <= '0;
         ctl_ff        <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         pos_ff        <= pos_in;
         hdr_ff        <= hdr_in;
         len_ff        <= len_in;
         sum_ff        <= sum_in;
         ctl_ff        <= ctl_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_ch.valid = out_valid_ff;
   assign rsp_ch.data  = out_data_ff;

endmodule

`default_nettype wire

// ===== sv/mfc_checker.sv =====
// ---------------------------------------------------------------------------
// mfc_checker
// Port-level checks on the frame checker's handshakes, bound to the core.
// ---------------------------------------------------------------------------
`default_nettype none

module mfc_checker (
   input wire clock,
   input wire reset,
   input wire req_valid,
   input wire req_ready,
   input wire req_last,
   input wire rsp_valid,
   input wire rsp_ready
);

   // a stalled result word stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   // a new result only follows an accepted last byte
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_last))
      else $error("result word without a last byte");

   // input back-pressure only while a result word is pending
   a_ready_low: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with no result pending");

   // input back-pressure starts only behind a stalled result
   a_ready_fall: assert property (@(posedge clock) disable iff (reset)
      $fell(req_ready) |-> $past(rsp_valid && !rsp_ready))
      else $error("input stalled while results drain");

endmodule

bind mail_frame_checker_core mfc_checker u_mfc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .req_last  (req_ch.data.chunk_last),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready)
);

`default_nettype wire
